// ===== design/wrip_pkg.sv =====
// Shared constants for the weighted random index picker: field widths,
// operation and status codes, and default sizes. No dependencies.
package wrip_pkg;

  // Field widths of the request and response items
  localparam int FUNC_W   = 2;
  localparam int IDX_W    = 4;
  localparam int WEIGHT_W = 16;
  localparam int RND_W    = 31;
  localparam int CFG_W    = 5;
  localparam int STATUS_W = 2;

  // Default sizes
  localparam int TABLE_DEPTH_DEF = 16;
  localparam int NEAR_FACTOR_DEF = 10;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FN_PICK  = 2'd1;
  localparam logic [FUNC_W-1:0] FN_NEAR  = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

endpackage

// ===== design/wrip_req_if.sv =====
// Request channel of the weighted random index picker: valid/ready plus
// the operation fields. Depends on wrip_pkg.
interface wrip_req_if;
  import wrip_pkg::*;

  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [IDX_W-1:0]    entry_index;
  logic [WEIGHT_W-1:0] weight_value;
  logic [RND_W-1:0]    random_value;

  modport source (output valid, func, entry_index, weight_value, random_value,
                  input ready);
  modport sink   (input valid, func, entry_index, weight_value, random_value,
                  output ready);
endinterface

// ===== design/wrip_rsp_if.sv =====
// Response channel of the weighted random index picker: valid/ready plus
// the picked index and status. Depends on wrip_pkg.
interface wrip_rsp_if;
  import wrip_pkg::*;

  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    picked_index;
  logic [STATUS_W-1:0] status;

  modport source (output valid, picked_index, status, input ready);
  modport sink   (input valid, picked_index, status, output ready);
endinterface

// ===== design/wrip_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module wrip_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one word, read one word a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/wrip_mod_unit.sv =====
// Iterative restoring remainder unit: one dividend bit per cycle.
// Used for random modulo total weight. No dependencies.
module wrip_mod_unit #(
  parameter int DIVIDEND_W = 31,
  parameter int DIVISOR_W  = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVISOR_W-1:0]  rem_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [DIVISOR_W-1:0]  div_q, div_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;

  // Shift in the next dividend bit and subtract when it fits
  assign trial = {rem_q, dvd_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIVIDEND_W);
      dvd_d  = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DIVIDEND_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[DIVISOR_W-1:0];
      end else begin
        rem_d = trial[DIVISOR_W-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operands and remainder
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== design/weighted_random_index_picker_unit.sv =====
// Weighted random index picker: weight table, global and near picks.
// From input accept to result: a write, a range error or an empty count goes
// straight to the result; a global pick takes two table walks over the n entries
// in use and the 31-step remainder unit; a near pick, three reads and that unit.
// One item at a time: ready only when idle, in the cycle after the result.
// Reset (rst_ni, async low): table reads as all zero, entry_count = 1.
module weighted_random_index_picker_unit #(
  parameter int TABLE_DEPTH = wrip_pkg::TABLE_DEPTH_DEF,
  parameter int NEAR_FACTOR = wrip_pkg::NEAR_FACTOR_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [wrip_pkg::CFG_W-1:0] cfg_data_i,
  wrip_req_if.sink                  req,
  wrip_rsp_if.source                rsp
);
  import wrip_pkg::*;

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int GSUM_W = WEIGHT_W + $clog2(TABLE_DEPTH);
  localparam int NSUM_W = WEIGHT_W + $clog2(NEAR_FACTOR + 2);
  localparam int SUM_W  = (GSUM_W > NSUM_W) ? GSUM_W : NSUM_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GSUM  = 4'd1;
  localparam logic [3:0] S_MOD   = 4'd2;
  localparam logic [3:0] S_GWALK = 4'd3;
  localparam logic [3:0] S_NREAD = 4'd4;
  localparam logic [3:0] S_NTOT  = 4'd5;
  localparam logic [3:0] S_NSEL  = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [3:0]             state_q, state_d;
  logic [CFG_W-1:0]       cfg_cnt_q;
  logic [TABLE_DEPTH-1:0] vld_q, vld_d;
  logic [CNT_W-1:0]       used_q, used_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   pend_q, pend_d;
  logic [1:0]             step_q, step_d;
  logic [FUNC_W-1:0]      func_q, func_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [RND_W-1:0]       rnd_q, rnd_d;
  logic [SUM_W-1:0]       acc_q, acc_d;
  logic [SUM_W-1:0]       mid_q, mid_d;
  logic [WEIGHT_W-1:0]    left_q, left_d;
  logic [WEIGHT_W-1:0]    right_q, right_d;
  logic [IDX_W-1:0]       out_idx_q, out_idx_d;
  logic [STATUS_W-1:0]    out_st_q, out_st_d;
  logic [AW-1:0]          rd_addr_q;

  logic [CNT_W-1:0]    used_now;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic                ram_we;
  logic [WEIGHT_W-1:0] ram_rdata;
  logic [WEIGHT_W-1:0] rword;
  logic [SUM_W-1:0]    acc_sum;
  logic [SUM_W-1:0]    near_sum;
  logic [SUM_W-1:0]    mid_left;
  logic                issue;
  logic                has_left;
  logic                has_right;
  logic                mod_start;
  logic [SUM_W-1:0]    mod_div;
  logic                mod_done;
  logic [SUM_W-1:0]    mod_rem;
  logic                in_fire;
  logic                out_fire;

  // Entries in use, clipped to the table depth
  always_comb begin
    if (32'(cfg_cnt_q) > 32'(TABLE_DEPTH)) begin
      used_now = CNT_W'(TABLE_DEPTH);
    end else begin
      used_now = CNT_W'(cfg_cnt_q);
    end
  end

  assign in_fire  = req.valid && req.ready;
  assign out_fire = rsp.valid && rsp.ready;
  assign waddr    = AW'(req.entry_index);

  // Unwritten entries read as zero
  assign rword = vld_q[rd_addr_q] ? ram_rdata : '0;

  // Shared accumulator adder
  assign acc_sum  = acc_q + SUM_W'(rword);
  assign near_sum = mid_q + SUM_W'(left_q) + SUM_W'(right_q);
  assign mid_left = mid_q + SUM_W'(left_q);

  assign issue     = (cnt_q < used_q);
  assign has_left  = (idx_q != '0);
  assign has_right = ((32'(idx_q) + 32'd1) < 32'(used_q));
  assign mod_div   = (state_q == S_NTOT) ? near_sum : acc_q;

  // Read address: table walk counter or near neighborhood
  always_comb begin
    if (state_q == S_NREAD) begin
      case (step_q)
        2'd1:    raddr = AW'(idx_q) - AW'(1);
        2'd2:    raddr = AW'(idx_q) + AW'(1);
        default: raddr = AW'(idx_q);
      endcase
    end else begin
      raddr = cnt_q[AW-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    vld_d     = vld_q;
    used_d    = used_q;
    cnt_d     = cnt_q;
    pend_d    = 1'b0;
    step_d    = step_q;
    func_d    = func_q;
    idx_d     = idx_q;
    rnd_d     = rnd_q;
    acc_d     = acc_q;
    mid_d     = mid_q;
    left_d    = left_q;
    right_d   = right_q;
    out_idx_d = out_idx_q;
    out_st_d  = out_st_q;
    ram_we    = 1'b0;
    mod_start = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          func_d    = req.func;
          idx_d     = req.entry_index;
          rnd_d     = req.random_value;
          used_d    = used_now;
          cnt_d     = '0;
          step_d    = '0;
          acc_d     = '0;
          out_idx_d = '0;
          out_st_d  = ST_OK;
          state_d   = S_OUT;
          case (req.func)
            FN_WRITE: begin
              if (32'(req.entry_index) < 32'(TABLE_DEPTH)) begin
                ram_we       = 1'b1;
                vld_d[waddr] = 1'b1;
              end else begin
                out_st_d = ST_RANGE;
              end
            end
            FN_PICK: begin
              if (used_now == '0) begin
                out_st_d = ST_ZERO;
              end else begin
                state_d = S_GSUM;
              end
            end
            FN_NEAR: begin
              if (32'(req.entry_index) >= 32'(used_now)) begin
                out_st_d = ST_RANGE;
              end else begin
                state_d = S_NREAD;
              end
            end
            default: begin
              out_st_d = ST_OK;
            end
          endcase
        end
      end
      S_GSUM: begin
        // Stream the entries in use through the accumulator
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        pend_d = issue;
        if (pend_q) begin
          acc_d = acc_sum;
        end
        if (!issue && !pend_q) begin
          if (acc_q == '0) begin
            out_st_d = ST_ZERO;
            state_d  = S_OUT;
          end else begin
            mod_start = 1'b1;
            state_d   = S_MOD;
          end
        end
      end
      S_MOD: begin
        if (mod_done) begin
          cnt_d = '0;
          acc_d = '0;
          if (func_q == FN_PICK) begin
            state_d = S_GWALK;
          end else begin
            state_d = S_NSEL;
          end
        end
      end
      S_GWALK: begin
        // Running sum until it passes the remainder
        if (issue) begin
          cnt_d = cnt_q + 1'b1;
        end
        pend_d = issue;
        if (pend_q) begin
          acc_d = acc_sum;
          if (mod_rem < acc_sum) begin
            out_idx_d = IDX_W'(rd_addr_q);
            pend_d    = 1'b0;
            state_d   = S_OUT;
          end
        end else if (!issue) begin
          state_d = S_OUT;
        end
      end
      S_NREAD: begin
        // Centre, left, right arrive in the cycle after their reads
        step_d = step_q + 1'b1;
        case (step_q)
          2'd1: begin
            mid_d = SUM_W'(rword) * SUM_W'(NEAR_FACTOR);
          end
          2'd2: begin
            left_d = has_left ? rword : '0;
          end
          2'd3: begin
            right_d = has_right ? rword : '0;
            state_d = S_NTOT;
          end
          default: begin
            step_d = 2'd1;
          end
        endcase
      end
      S_NTOT: begin
        if (near_sum == '0) begin
          out_st_d = ST_ZERO;
          state_d  = S_OUT;
        end else begin
          mod_start = 1'b1;
          state_d   = S_MOD;
        end
      end
      S_NSEL: begin
        if (mod_rem < mid_q) begin
          out_idx_d = idx_q;
        end else if (has_left && (mod_rem < mid_left)) begin
          out_idx_d = idx_q - 1'b1;
        end else begin
          out_idx_d = idx_q + 1'b1;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cfg_cnt_q <= CFG_W'(1);
      vld_q     <= '0;
      pend_q    <= 1'b0;
      cnt_q     <= '0;
      step_q    <= '0;
      used_q    <= '0;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      used_q  <= used_d;
      if (cfg_we_i) begin
        cfg_cnt_q <= cfg_data_i;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    idx_q     <= idx_d;
    rnd_q     <= rnd_d;
    acc_q     <= acc_d;
    mid_q     <= mid_d;
    left_q    <= left_d;
    right_q   <= right_d;
    out_idx_q <= out_idx_d;
    out_st_q  <= out_st_d;
    rd_addr_q <= raddr;
  end

  wrip_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (req.weight_value),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  wrip_mod_unit #(
    .DIVIDEND_W (RND_W),
    .DIVISOR_W  (SUM_W)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (rnd_q),
    .divisor_i  (mod_div),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  assign req.ready        = (state_q == S_IDLE);
  assign rsp.valid        = (state_q == S_OUT);
  assign rsp.picked_index = out_idx_q;
  assign rsp.status       = out_st_q;

endmodule

// ===== tb/tb_weighted_random_index_picker_unit.sv =====
// Self-checking testbench for weighted_random_index_picker_unit: directed
// and random writes, global picks and near picks under varying entry counts.
// Depends on wrip_pkg, wrip_req_if, wrip_rsp_if and the picker RTL.
`timescale 1ns / 100ps

module tb_weighted_random_index_picker_unit;
  import wrip_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 100;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [IDX_W-1:0]    index;
    logic [STATUS_W-1:0] status;
  } pick_result_t;

  // Shadow copy of the weight table; computes and queues expected picks
  class pick_tracker;
    logic [WEIGHT_W-1:0] weights [TABLE_DEPTH_DEF];
    logic [CFG_W-1:0]    entry_count;
    pick_result_t        awaited [$];
    int                  mismatch_count;

    function new();
      foreach (weights[k]) weights[k] = '0;
      entry_count = 5'd1;
      mismatch_count = 0;
    endfunction

    // Apply one request to the shadow table and queue its outcome
    function void note_request(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] idx,
                               logic [WEIGHT_W-1:0] w, logic [RND_W-1:0] rnd);
      pick_result_t outcome;
      int unsigned  span, sum, run, rem, centre, left, right;
      bit           found;
      outcome.index = '0;
      outcome.status = ST_OK;
      span = (entry_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : entry_count;
      case (func)
        FN_WRITE: begin
          weights[idx] = w;
        end
        FN_PICK: begin
          sum = 0;
          for (int k = 0; k < span; k++) sum += weights[k];
          if (sum == 0) begin
            outcome.status = ST_ZERO;
          end else begin
            rem = rnd % sum;
            run = 0;
            found = 0;
            for (int k = 0; k < span; k++) begin
              run += weights[k];
              if (!found && rem < run) begin
                outcome.index = IDX_W'(k);
                found = 1;
              end
            end
          end
        end
        FN_NEAR: begin
          if (idx >= span) begin
            outcome.status = ST_RANGE;
          end else begin
            centre = weights[idx] * NEAR_FACTOR_DEF;
            left = (idx > 0) ? weights[idx-1] : 0;
            right = (idx + 1 < span) ? weights[idx+1] : 0;
            sum = centre + left + right;
            if (sum == 0) begin
              outcome.status = ST_ZERO;
            end else begin
              rem = rnd % sum;
              if (rem < centre) outcome.index = idx;
              else if (idx > 0 && rem < centre + left) outcome.index = idx - 1'b1;
              else outcome.index = idx + 1'b1;
            end
          end
        end
        default: ;
      endcase
      awaited.insert(awaited.size(), outcome);
    endfunction

    // Compare one response with the oldest queued outcome
    function void check_response(logic [IDX_W-1:0] idx, logic [STATUS_W-1:0] st);
      pick_result_t want;
      if (awaited.size() == 0) begin
        mismatch_count++;
        $display("%0t: response with nothing pending: index %0d status %0d",
                 $time, idx, st);
        return;
      end
      want = awaited.pop_front();
      if (idx !== want.index) begin
        mismatch_count++;
        $display("%0t: picked_index expected %0d actual %0d", $time, want.index, idx);
      end
      if (st !== want.status) begin
        mismatch_count++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CFG_W-1:0]    cfg_data_i;
  pick_tracker         tracker;
  bit                  calm;
  bit                  long_hold_req;
  int                  idle_cycles = 0;

  wrip_req_if req_ch ();
  wrip_rsp_if rsp_ch ();

  weighted_random_index_picker_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Offer one item after an optional idle burst; hold until accepted
  task automatic send_item(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] idx,
                           input logic [WEIGHT_W-1:0] w, input logic [RND_W-1:0] rnd);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.func         <= func;
    req_ch.entry_index  <= idx;
    req_ch.weight_value <= w;
    req_ch.random_value <= rnd;
    do @(posedge clk_i); while (!req_ch.ready);
    tracker.note_request(func, idx, w, rnd);
  endtask

  // Drop the request, drain all responses, then write the entry count
  task automatic set_entry_count(input logic [CFG_W-1:0] count);
    req_ch.valid <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= count;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.entry_count = count;
  endtask

  // Random item, biased toward entries in use and edge weights
  task automatic send_random_item();
    logic [FUNC_W-1:0]   func;
    logic [IDX_W-1:0]    idx;
    logic [WEIGHT_W-1:0] w;
    logic [RND_W-1:0]    rnd;
    int                  span;
    int                  sel;
    sel = $urandom_range(0, 99);
    func = (sel < 35) ? FN_WRITE : (sel < 65) ? FN_PICK : (sel < 95) ? FN_NEAR : FN_UNUSED;
    span = (tracker.entry_count > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : tracker.entry_count;
    if (span > 0 && $urandom_range(0, 3) != 0) idx = IDX_W'($urandom_range(0, span - 1));
    else idx = IDX_W'($urandom_range(0, TABLE_DEPTH_DEF - 1));
    sel = $urandom_range(0, 9);
    if (sel < 2) w = '0;
    else if (sel < 4) w = '1;
    else if (sel < 7) w = WEIGHT_W'($urandom_range(1, 15));
    else w = WEIGHT_W'($urandom);
    sel = $urandom_range(0, 9);
    if (sel < 2) rnd = RND_W'($urandom_range(0, 255));
    else if (sel == 2) rnd = '1;
    else rnd = RND_W'($urandom);
    send_item(func, idx, w, rnd);
  endtask

  // Check every accepted response
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready)
      tracker.check_response(rsp_ch.picked_index, rsp_ch.status);
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[weighted_random_index_picker_unit] ERROR");
        $finish;
      end
    end
  end

  // Response side: random stall bursts, one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    rsp_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (long_hold_req && !held) begin
        held = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  initial begin
    int phase_counts [10];
    tracker = new();
    calm = 0;
    long_hold_req = 0;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_data_i <= '0;
    req_ch.valid <= 1'b0;
    req_ch.func <= FN_WRITE;
    req_ch.entry_index <= '0;
    req_ch.weight_value <= '0;
    req_ch.random_value <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One entry in use after reset: empty table, out-of-range centre
    send_item(FN_PICK, 4'd0, 16'h0000, 31'd0);
    send_item(FN_NEAR, 4'd0, 16'h0000, '1);
    send_item(FN_NEAR, 4'd15, 16'h0000, 31'd7);
    send_item(FN_WRITE, 4'd0, 16'hFFFF, 31'd0);
    // Write beyond the entries in use
    send_item(FN_WRITE, 4'd15, 16'h0001, 31'd0);
    send_item(FN_PICK, 4'd0, 16'h0000, '1);
    send_item(FN_NEAR, 4'd0, 16'h0000, 31'd0);
    send_item(FN_UNUSED, 4'd15, 16'hFFFF, '1);

    // Full table: edge centres, one-sided neighbours
    set_entry_count(5'd16);
    send_item(FN_WRITE, 4'd14, 16'hFFFF, 31'd0);
    send_item(FN_NEAR, 4'd15, 16'h0000, '1);
    send_item(FN_NEAR, 4'd14, 16'h0000, 31'd0);
    send_item(FN_NEAR, 4'd1, 16'h0000, 31'h12345);
    send_item(FN_PICK, 4'd0, 16'h0000, '1);
    send_item(FN_PICK, 4'd0, 16'h0000, 31'd0);
    send_item(FN_WRITE, 4'd0, 16'h0000, 31'd0);
    // Centre and neighbours all zero
    send_item(FN_NEAR, 4'd3, 16'h0000, 31'd5);

    // No entries in use
    set_entry_count(5'd0);
    send_item(FN_PICK, 4'd0, 16'h0000, 31'd9);
    send_item(FN_NEAR, 4'd0, 16'h0000, 31'd9);

    // Count above the table size acts as the full table
    set_entry_count(5'd31);
    send_item(FN_PICK, 4'd0, 16'h0000, '1);
    send_item(FN_NEAR, 4'd15, 16'h0000, 31'h55555555);

    // Random phases over several entry counts
    phase_counts = '{16, 3, 31, 1, 8, 0, 16, 2, 17, 12};
    phase_counts[4] = $urandom_range(1, 16);
    foreach (phase_counts[p]) begin
      set_entry_count(CFG_W'(phase_counts[p]));
      if (p == 2) long_hold_req = 1;
      if (p == 9) calm = 1;
      repeat (ITEMS_PER_PHASE) send_random_item();
    end
    req_ch.valid <= 1'b0;

    // Drain and settle
    while (tracker.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.mismatch_count == 0 && tracker.awaited.size() == 0) begin
      $display("[weighted_random_index_picker_unit] OK");
    end else begin
      $display("[weighted_random_index_picker_unit] ERROR");
    end
    $finish;
  end

endmodule
